// ----- design/mstd_pkg.sv -----
// mstd_pkg: shared widths, defaults and the per-set sums record
// used by the front accumulator, the set queue and the back engine
// no dependencies
package mstd_pkg;

  localparam int SampleW    = 16;
  localparam int CntW       = 9;
  localparam int SumW       = 24;
  localparam int SqSumW     = 40;
  localparam int NumW       = 48;
  // root of the full variance numerator, half its width
  localparam int RootW      = 24;
  localparam int RecipW     = 26;
  localparam int StepW      = 5;
  localparam int QueueDepth = 2;

  localparam int SampleCountDef = 8;

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [SqSumW-1:0] square_sum;
  } set_sums_t;

endpackage

// ----- design/mean_and_std_deviation.sv -----
// mean_and_std_deviation: population mean and standard deviation over
// sets of SAMPLE_COUNT Q0.16 samples; front accumulator, set queue, back engine
// depends on mstd_pkg, mstd_front, mstd_fifo, mstd_back
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------
//   samples  | start / busy       | sample_i
//   results  | valid_o (strobe)   | mean_o, std_deviation_o
//
// the front takes one sample a cycle while busy is low; the last sample of a set pushes its sums
// busy is high while the set queue is full
// the back engine works on one set at a time: the pop, the products and the mean,
// the variance numerator, 24 square-root steps and the root divided by the set size
// the front gathers the next set while the engine works, with room for two sets of sums in the queue
// results appear for one cycle on valid_o; the receiver cannot stall
// asynchronous active-low reset clears the counters, the queue and the engine
module mean_and_std_deviation #(
  parameter int SAMPLE_COUNT = mstd_pkg::SampleCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [mstd_pkg::SampleW-1:0] sample_i,
  output logic                         valid_o,
  output logic [mstd_pkg::SampleW-1:0] mean_o,
  output logic [mstd_pkg::SampleW-1:0] std_deviation_o
);

  logic                accept;
  logic                push, pop, q_empty, q_full;
  mstd_pkg::set_sums_t push_data, pop_data;

  assign busy   = q_full;
  assign accept = start && !busy;

  mstd_front #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .push_o     (push),
    .push_data_o(push_data)
  );

  mstd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  mstd_back #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .mean_o         (mean_o),
    .std_deviation_o(std_deviation_o)
  );

endmodule

// ----- design/mstd_front.sv -----
// mstd_front: takes samples, keeps count, sum and sum of squares,
// hands the sums of each complete set to the queue
// depends on mstd_pkg
module mstd_front #(
  parameter int SAMPLE_COUNT = mstd_pkg::SampleCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [mstd_pkg::SampleW-1:0]    sample_i,
  output logic                            push_o,
  output mstd_pkg::set_sums_t             push_data_o
);

  localparam logic [mstd_pkg::CntW-1:0] NCnt = mstd_pkg::CntW'(SAMPLE_COUNT);

  logic [mstd_pkg::CntW-1:0]   count_q, count_d, count_inc;
  logic [mstd_pkg::SumW-1:0]   sum_q, sum_d, sum_add;
  logic [mstd_pkg::SqSumW-1:0] sq_q, sq_d, sq_add;
  logic [2*mstd_pkg::SampleW-1:0] sample_sq;
  logic                        last;

  assign sample_sq = sample_i * sample_i;
  assign sum_add   = sum_q + mstd_pkg::SumW'(sample_i);
  assign sq_add    = sq_q + mstd_pkg::SqSumW'(sample_sq);
  assign count_inc = count_q + mstd_pkg::CntW'(1);
  assign last      = (count_inc == NCnt);

  assign push_o                 = accept_i && last;
  assign push_data_o.sum        = sum_add;
  assign push_data_o.square_sum = sq_add;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    if (accept_i) begin
      if (last) begin
        count_d = '0;
        sum_d   = '0;
        sq_d    = '0;
      end else begin
        count_d = count_inc;
        sum_d   = sum_add;
        sq_d    = sq_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
    end
  end

endmodule

// ----- design/mstd_fifo.sv -----
// mstd_fifo: short queue of per-set sums between front and back
// depends on mstd_pkg
module mstd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mstd_pkg::set_sums_t push_data_i,
  input  logic                pop_i,
  output mstd_pkg::set_sums_t pop_data_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int Depth = mstd_pkg::QueueDepth;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  mstd_pkg::set_sums_t entry_q [Depth];
  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                do_push, do_pop;

  assign empty_o    = (fill_q == '0);
  assign full_o     = (fill_q == FillW'(Depth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/mstd_back.sv -----
// mstd_back: turns the sums of one set into mean and deviation
// with reciprocal multiplies by the set size and a digit-by-digit square root
// depends on mstd_pkg
module mstd_back #(
  parameter int SAMPLE_COUNT = mstd_pkg::SampleCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  mstd_pkg::set_sums_t          pop_data_i,
  output logic                         pop_o,
  output logic                         valid_o,
  output logic [mstd_pkg::SampleW-1:0] mean_o,
  output logic [mstd_pkg::SampleW-1:0] std_deviation_o
);

  localparam int SumW   = mstd_pkg::SumW;
  localparam int SqW    = mstd_pkg::SqSumW;
  localparam int NumW   = mstd_pkg::NumW;
  localparam int RootW  = mstd_pkg::RootW;
  localparam int RecipW = mstd_pkg::RecipW;
  localparam int StepW  = mstd_pkg::StepW;
  localparam int CntW   = mstd_pkg::CntW;
  localparam int OutW   = mstd_pkg::SampleW;

  localparam logic [CntW-1:0] NCnt = CntW'(SAMPLE_COUNT);

  // floor(x / N) is (x * Recip) >> RecipShift for every x below 2**SumW
  localparam int RecipShift = SumW + $clog2(SAMPLE_COUNT);
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSub  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             valid_q, valid_d;

  logic [SumW-1:0]         s1_q;
  logic [SqW-1:0]          s2_q;
  logic [NumW-1:0]         psq_q, pn_q, num_q;
  logic [2*SumW-1:0]       psq_full;
  logic [NumW+CntW-1:0]    pn_full;
  logic [SumW+RecipW-1:0]  mean_prod;
  logic [RootW+RecipW-1:0] std_prod;
  logic [RootW+1:0]        sq_rem_q, sq_rem_nx, sq_trial;
  logic [RootW+3:0]        sq_t;
  logic [RootW-1:0]        root_q, root_nx;
  logic                    sq_ge;
  logic [OutW-1:0]         mean_q, std_q;

  assign psq_full  = s1_q * s1_q;
  assign pn_full   = s2_q * NCnt;
  assign mean_prod = s1_q * Recip;
  // floor(sqrt(num / N^2)) equals floor(floor(sqrt(num)) / N)
  assign std_prod  = root_q * Recip;

  // one root bit a cycle, radicand taken two bits at a time from the numerator
  assign sq_t      = {sq_rem_q, num_q[NumW-1 -: 2]};
  assign sq_trial  = {root_q, 2'b01};
  assign sq_ge     = (sq_t >= {2'b00, sq_trial});
  assign sq_rem_nx = sq_ge ? (RootW + 2)'(sq_t - {2'b00, sq_trial}) : sq_t[RootW+1:0];
  assign root_nx   = {root_q[RootW-2:0], sq_ge};

  assign pop_o           = (state_q == StIdle) && !empty_i;
  assign valid_o         = valid_q;
  assign mean_o          = mean_q;
  assign std_deviation_o = std_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StSub;
      end
      StSub: begin
        state_d = StSqrt;
        step_d  = StepW'(RootW - 1);
      end
      StSqrt: begin
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        state_d = StIdle;
        valid_d = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        s1_q <= pop_data_i.sum;
        s2_q <= pop_data_i.square_sum;
      end
      StMul: begin
        psq_q  <= NumW'(psq_full);
        pn_q   <= pn_full[NumW-1:0];
        mean_q <= mean_prod[RecipShift +: OutW];
      end
      StSub: begin
        num_q    <= (pn_q >= psq_q) ? pn_q - psq_q : '0;
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      StSqrt: begin
        num_q    <= {num_q[NumW-3:0], 2'b00};
        sq_rem_q <= sq_rem_nx;
        root_q   <= root_nx;
      end
      StDiv: begin
        std_q <= std_prod[RecipShift +: OutW];
      end
      default: begin
        s1_q <= s1_q;
      end
    endcase
  end

endmodule

// ----- design/mstd_checker.sv -----
// mstd_assert: port-level checks on mean_and_std_deviation
// depends on mstd_pkg; bound to the top level below
module mstd_assert (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         valid_o,
  input logic [mstd_pkg::SampleW-1:0] std_deviation_o
);

  // the back engine never gives two results back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("back-to-back results");

  // a deviation of values in [0,1) stays below one half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !std_deviation_o[mstd_pkg::SampleW-1])
    else $error("deviation out of range");

  // the queue only fills on a transaction that closes a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  // busy cannot last past the time the engine needs to drain a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) && $past(busy) |=> !busy)
    else $error("queue not freed after a result");

endmodule

bind mean_and_std_deviation mstd_assert u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .valid_o        (valid_o),
  .std_deviation_o(std_deviation_o)
);

// ----- tb/sv/mstd_checker.sv -----
`timescale 1ns / 100ps
// mstd_checker: watches the sample and result channels of mean_and_std_deviation,
// predicts the mean and deviation of every completed set and compares field by field
// depends on mstd_pkg
module mstd_checker #(
  parameter int SAMPLE_COUNT = mstd_pkg::SampleCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [mstd_pkg::SampleW-1:0] sample_i,
  input  logic                         valid_i,
  input  logic [mstd_pkg::SampleW-1:0] mean_i,
  input  logic [mstd_pkg::SampleW-1:0] std_deviation_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int SampleW = mstd_pkg::SampleW;
  localparam int CntW    = mstd_pkg::CntW;
  localparam int SumW    = mstd_pkg::SumW;
  localparam int SqSumW  = mstd_pkg::SqSumW;

  typedef struct packed {
    logic [SampleW-1:0] mean;
    logic [SampleW-1:0] std_deviation;
  } set_stats_t;

  set_stats_t        expected_stats[$];
  logic [CntW-1:0]   samples_in_set;
  logic [SumW-1:0]   set_sum;
  logic [SqSumW-1:0] set_square_sum;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [63:0] set_size;
    logic [63:0] numer;
    logic [63:0] sum_sq;
    logic [63:0] variance;
    logic [63:0] root;
    logic [63:0] trial;
    set_stats_t  want;
    if (!rst_ni) begin
      samples_in_set = '0;
      set_sum        = '0;
      set_square_sum = '0;
      expected_stats.delete();
      pending_o      = 0;
      fail_count_o   = 0;
    end else begin
      // results come out of the back engine long after the last sample,
      // so the result of this edge never belongs to the sample of this edge
      if (valid_i) begin
        if (expected_stats.size() == 0) begin
          $error("result transaction with none expected: mean %0d std_deviation %0d",
                 mean_i, std_deviation_i);
          fail_count_o++;
        end else begin
          want = expected_stats.pop_front();
          if (mean_i !== want.mean) begin
            $error("mean: expected %0d, actual %0d", want.mean, mean_i);
            fail_count_o++;
          end
          if (std_deviation_i !== want.std_deviation) begin
            $error("std_deviation: expected %0d, actual %0d",
                   want.std_deviation, std_deviation_i);
            fail_count_o++;
          end
        end
      end

      if (start_i && !busy_i) begin
        set_sum        = set_sum + SumW'(sample_i);
        set_square_sum = set_square_sum + SqSumW'(sample_i) * SqSumW'(sample_i);
        samples_in_set = samples_in_set + 1'b1;

        if (samples_in_set >= SAMPLE_COUNT) begin
          set_size = 64'(SAMPLE_COUNT);
          numer    = set_size * 64'(set_square_sum);
          sum_sq   = 64'(set_sum) * 64'(set_sum);
          numer    = (numer >= sum_sq) ? numer - sum_sq : '0;
          variance = numer / (set_size * set_size);

          // floor of the root, one result bit at a time from the top
          root = '0;
          for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= variance) root = trial;
          end

          want.mean          = SampleW'(64'(set_sum) / set_size);
          want.std_deviation = SampleW'(root);
          expected_stats.push_back(want);

          samples_in_set = '0;
          set_sum        = '0;
          set_square_sum = '0;
        end
      end
      pending_o = expected_stats.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives sample sets into mean_and_std_deviation with random idling
// and reports the verdict; depends on mstd_pkg, mstd_checker and the block itself
module tb_top;

  localparam int SampleW     = mstd_pkg::SampleW;
  localparam int SetSize     = mstd_pkg::SampleCountDef;
  localparam int RandomSets  = 172;
  localparam int MaxGap      = 30;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 200;

  typedef enum int {
    ShapeFull,
    ShapeLow,
    ShapeHigh,
    ShapeFlat,
    ShapeTwoLevel,
    ShapeNarrow
  } set_shape_e;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [SampleW-1:0] sample_i;
  logic               valid_o;
  logic [SampleW-1:0] mean_o;
  logic [SampleW-1:0] std_deviation_o;
  int                 fail_count;
  int                 pending;

  mean_and_std_deviation #(
    .SAMPLE_COUNT(SetSize)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .valid_o        (valid_o),
    .mean_o         (mean_o),
    .std_deviation_o(std_deviation_o)
  );

  mstd_checker #(
    .SAMPLE_COUNT(SetSize)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .sample_i       (sample_i),
    .valid_i        (valid_o),
    .mean_i         (mean_o),
    .std_deviation_i(std_deviation_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // start stays high from one transaction to the next unless a gap is drawn
  task automatic send_sample(input logic [SampleW-1:0] value, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start    <= 1'b0;
      sample_i <= SampleW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin : stimulus
    int                 idle_pct;
    set_shape_e         shape;
    logic [SampleW-1:0] level;
    logic [SampleW-1:0] spread;
    logic [SampleW-1:0] value;
    start    = 1'b0;
    sample_i = '0;
    rst_ni   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all zero, all full scale, then alternating extremes for the widest deviation
    for (int i = 0; i < SetSize; i++) send_sample('0, 28);
    for (int i = 0; i < SetSize; i++) send_sample('1, 28);
    for (int i = 0; i < SetSize; i++) send_sample((i % 2 != 0) ? '1 : '0, 28);

    for (int s = 0; s < RandomSets; s++) begin
      if (s < RandomSets / 3) idle_pct = 28;
      else if (s < 2 * RandomSets / 3) idle_pct = 70;
      else idle_pct = 0;

      shape  = set_shape_e'($urandom_range(0, 5));
      level  = SampleW'($urandom);
      spread = SampleW'(1 << $urandom_range(0, 15));
      for (int i = 0; i < SetSize; i++) begin
        case (shape)
          ShapeFull:     value = SampleW'($urandom);
          ShapeLow:      value = SampleW'($urandom_range(0, 255));
          ShapeHigh:     value = 16'hFFFF - SampleW'($urandom_range(0, 255));
          ShapeFlat:     value = level;
          ShapeTwoLevel: value = $urandom_range(0, 1) ? level : 16'hFFFF - level;
          default:       value = level + SampleW'($urandom_range(0, spread));
        endcase
        send_sample(value, idle_pct);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    // room for a stray result from the back engine
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("mean_and_std_deviation verification clean");
    end else begin
      $display("mean_and_std_deviation verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || valid_o) quiet = 0;
      else quiet++;
    end
    $display("mean_and_std_deviation verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mstd_pkg.sv
design/mstd_front.sv
design/mstd_fifo.sv
design/mstd_back.sv
design/mean_and_std_deviation.sv
design/mstd_checker.sv
tb/sv/mstd_checker.sv
tb/sv/tb_top.sv
